### design/sksbus_pkg.sv
package sksbus_pkg;

    // Port widths fixed by the item format
    localparam int ADC_W      = 10;
    localparam int KEY_W      = 8;
    localparam int CH_W       = 11;
    localparam int CH_COUNT   = 16;
    localparam int FRAME_BITS = CH_W * CH_COUNT;
    localparam int DATA_BYTES = FRAME_BITS / 8;
    localparam int STICKS     = 4;

    localparam logic [7:0]      HEADER_BYTE = 8'h0F;
    localparam logic [CH_W-1:0] CH_FULL     = 11'h7FF;
    localparam logic [4:0]      LAST_POS    = 5'd24;

    // Configuration register indexes and reset values
    localparam logic [1:0] REG_CENTER = 2'd0;
    localparam logic [1:0] REG_HIGH   = 2'd1;
    localparam logic [1:0] REG_LOW    = 2'd2;

    localparam logic [9:0]      CENTER_RST = 10'd512;
    localparam logic [CH_W-1:0] HIGH_RST   = 11'd1900;
    localparam logic [CH_W-1:0] LOW_RST    = 11'd50;

    typedef enum logic [2:0] {
        OP_SAMPLE     = 3'd0,
        OP_CAL_CLEAR  = 3'd1,
        OP_CAL_SAMPLE = 3'd2,
        OP_CAL_FINISH = 3'd3,
        OP_KEY_SCAN   = 3'd4,
        OP_EMIT       = 3'd5
    } op_t;

    typedef logic [FRAME_BITS-1:0] frame_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

### design/sksbus_front.sv
module sksbus_front
    import sksbus_pkg::*;
#(
    parameter int ADC_BITS  = 10,
    parameter int KEY_COUNT = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         operation,
    input  logic [ADC_W-1:0]   adc_left_h,
    input  logic [ADC_W-1:0]   adc_left_v,
    input  logic [ADC_W-1:0]   adc_right_h,
    input  logic [ADC_W-1:0]   adc_right_v,
    input  logic [KEY_W-1:0]   key_levels,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [CH_W-1:0]    cfg_wdata,
    input  fifo_status_t       q_status,
    output logic               push,
    output frame_t             push_frame
);

    localparam logic [15:0] ADC_MASK = 16'((32'd1 << ADC_BITS) - 32'd1);

    logic [9:0]      center_reg;
    logic [CH_W-1:0] high_reg;
    logic [CH_W-1:0] low_reg;

    logic [15:0] avg_reg  [STICKS];
    logic [15:0] avg_next [STICKS];
    logic [15:0] cal_reg  [STICKS];
    logic [15:0] cal_next [STICKS];
    logic [15:0] off_reg  [STICKS];
    logic [15:0] off_next [STICKS];
    logic [KEY_W-1:0] held_reg;
    logic [KEY_W-1:0] held_next;
    logic [KEY_W-1:0] parity_reg;
    logic [KEY_W-1:0] parity_next;

    logic [15:0] adc_ext  [STICKS];
    logic [16:0] avg_sum  [STICKS];
    logic [16:0] cal_sum  [STICKS];
    logic [15:0] emit_sum [STICKS];
    logic [15:0] emit_avg [STICKS];
    logic [15:0] fin_off  [STICKS];
    logic [KEY_W-1:0] scan_held;
    logic [KEY_W-1:0] scan_parity;
    logic [CH_W-1:0]  ch [CH_COUNT];
    logic accept;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && (operation == OP_EMIT);

    // Mask samples to the converter width
    assign adc_ext[0] = 16'(adc_left_h)  & ADC_MASK;
    assign adc_ext[1] = 16'(adc_left_v)  & ADC_MASK;
    assign adc_ext[2] = 16'(adc_right_h) & ADC_MASK;
    assign adc_ext[3] = 16'(adc_right_v) & ADC_MASK;

    // Per-stick datapath: running averages, offset, emit scaling
    for (genvar c = 0; c < STICKS; c++) begin : g_stick
        assign avg_sum[c]  = {1'b0, avg_reg[c]} + {1'b0, adc_ext[c]};
        assign cal_sum[c]  = {1'b0, cal_reg[c]} + {1'b0, adc_ext[c]};
        assign fin_off[c]  = {6'd0, center_reg} - cal_reg[c];
        assign emit_sum[c] = avg_reg[c] + off_reg[c];
        assign emit_avg[c] = {emit_sum[c][14:0], 1'b0};
    end

    // Key edge detect: only keys 1..KEY_COUNT-1 are scanned
    for (genvar k = 0; k < KEY_W; k++) begin : g_key
        if (k >= 1 && k < KEY_COUNT) begin : g_scan
            assign scan_held[k]   = !key_levels[k];
            assign scan_parity[k] = parity_reg[k] ^ (!key_levels[k] && !held_reg[k]);
        end
        else begin : g_idle
            assign scan_held[k]   = held_reg[k];
            assign scan_parity[k] = parity_reg[k];
        end
    end

    // Select state updates by operation
    always_comb
    begin
        avg_next    = avg_reg;
        cal_next    = cal_reg;
        off_next    = off_reg;
        held_next   = held_reg;
        parity_next = parity_reg;
        if (accept)
        begin
            case (operation)
                OP_SAMPLE:
                begin
                    for (int c = 0; c < STICKS; c++)
                        avg_next[c] = avg_sum[c][16:1];
                end
                OP_CAL_CLEAR:
                begin
                    for (int c = 0; c < STICKS; c++)
                        cal_next[c] = 16'd0;
                end
                OP_CAL_SAMPLE:
                begin
                    for (int c = 0; c < STICKS; c++)
                        cal_next[c] = cal_sum[c][16:1];
                end
                OP_CAL_FINISH:
                begin
                    for (int c = 0; c < STICKS; c++)
                        off_next[c] = fin_off[c];
                end
                OP_KEY_SCAN:
                begin
                    held_next   = scan_held;
                    parity_next = scan_parity;
                end
                OP_EMIT:
                begin
                    for (int c = 0; c < STICKS; c++)
                        avg_next[c] = emit_avg[c];
                end
                default:
                begin
                    avg_next = avg_reg;
                end
            endcase
        end
    end

    // Form the sixteen channels from the post-emit averages
    always_comb
    begin
        for (int c = 0; c < CH_COUNT; c++)
            ch[c] = CH_FULL;
        if (held_reg[1])
        begin
            ch[0] = high_reg;
            ch[1] = high_reg;
            ch[2] = low_reg;
            ch[3] = high_reg;
        end
        else
        begin
            for (int c = 0; c < STICKS; c++)
                ch[c] = emit_avg[c][CH_W-1:0];
        end
        if (held_reg[2])
        begin
            ch[0] = low_reg;
            ch[1] = high_reg;
        end
        for (int k = 3; k < 8; k++)
            ch[k+3] = parity_reg[k] ? low_reg : high_reg;
    end

    // Pack channels LSB first
    always_comb
    begin
        for (int c = 0; c < CH_COUNT; c++)
            push_frame[c*CH_W +: CH_W] = ch[c];
    end

    // Hold stick and key state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < STICKS; c++)
            begin
                avg_reg[c] <= 16'd0;
                cal_reg[c] <= 16'd0;
                off_reg[c] <= 16'd0;
            end
            held_reg   <= '0;
            parity_reg <= '0;
        end
        else
        begin
            avg_reg    <= avg_next;
            cal_reg    <= cal_next;
            off_reg    <= off_next;
            held_reg   <= held_next;
            parity_reg <= parity_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= CENTER_RST;
            high_reg   <= HIGH_RST;
            low_reg    <= LOW_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTER: center_reg <= cfg_wdata[9:0];
                REG_HIGH:   high_reg   <= cfg_wdata;
                REG_LOW:    low_reg    <= cfg_wdata;
                default:    center_reg <= center_reg;
            endcase
        end
    end

    // Key 0 is never scanned
    a_key0_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !held_reg[0] && !parity_reg[0])
        else $error("key 0 state changed");

    // A scan press of key 1 toggles parity when the key was released
    a_press_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_KEY_SCAN && !key_levels[1] && !held_reg[1])
        |=> (held_reg[1] && parity_reg[1] != $past(parity_reg[1])))
        else $error("press edge did not toggle parity");

    // Emit only when the queue has room
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("frame pushed into full queue");

endmodule

### design/sksbus_fifo.sv
module sksbus_fifo
    import sksbus_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  frame_t       push_frame,
    input  logic         pop,
    output frame_t       head_frame,
    output fifo_status_t status
);

    frame_t slot0_reg;
    frame_t slot1_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign head_frame   = slot0_reg;
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    assign count_next = count_reg + {1'b0, push} - {1'b0, pop};

    // Occupancy count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    // Two-slot shift queue, head always in slot0
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            slot0_reg <= (push && count_reg == 2'd1) ? push_frame : slot1_reg;
            if (push && count_reg == 2'd2)
                slot1_reg <= push_frame;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
                slot0_reg <= push_frame;
            else
                slot1_reg <= push_frame;
        end
    end

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("pop from empty queue");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg != 2'd0))
        else $error("pushed frame lost");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue overflow");

endmodule

### design/sksbus_ser.sv
module sksbus_ser
    import sksbus_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  frame_t       head_frame,
    input  fifo_status_t q_status,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   frame_byte,
    output logic [4:0]   byte_position,
    output logic         last_byte
);

    logic [4:0] pos_reg;
    logic [4:0] pos_next;
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic [4:0] opos_reg;
    logic       last_reg;
    logic       load;
    logic       advance;
    logic [7:0] data_bytes [DATA_BYTES];
    logic [4:0] data_idx;

    for (genvar b = 0; b < DATA_BYTES; b++) begin : g_bytes
        assign data_bytes[b] = head_frame[b*8 +: 8];
    end

    assign advance  = !valid_reg || out_ready;
    assign load     = advance && !q_status.empty;
    assign pop      = load && (pos_reg == LAST_POS);
    assign data_idx = pos_reg - 5'd1;

    // Pick the byte at the current frame position
    always_comb
    begin
        if (pos_reg == 5'd0)
            byte_next = HEADER_BYTE;
        else if (pos_reg <= 5'(DATA_BYTES))
            byte_next = data_bytes[data_idx];
        else
            byte_next = 8'd0;
    end

    // Advance the position, wrap after the last byte
    always_comb
    begin
        pos_next   = pos_reg;
        valid_next = valid_reg;
        if (advance)
            valid_next = !q_status.empty;
        if (load)
            pos_next = (pos_reg == LAST_POS) ? 5'd0 : pos_reg + 5'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 5'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    // Output beat register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_next;
            opos_reg <= pos_reg;
            last_reg <= (pos_reg == LAST_POS);
        end
    end

    assign out_valid     = valid_reg;
    assign frame_byte    = byte_reg;
    assign byte_position = opos_reg;
    assign last_byte     = last_reg;

    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (pos_reg == 5'd0 && valid_reg && last_reg))
        else $error("frame did not close on last byte");

    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && opos_reg == 5'd0) |-> (byte_reg == HEADER_BYTE))
        else $error("bad header byte");

    a_trailer: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && opos_reg > 5'(DATA_BYTES)) |-> (byte_reg == 8'd0))
        else $error("nonzero trailer byte");

endmodule

### design/stick_keys_to_sbus_frame.sv
// Stick/key to SBUS frame encoder.
// Ops 0-4 update state at the accept edge. An emit's frame is registered in the queue, then
// in the serializer's beat register, and leaves one beat per cycle while out_ready is high.
// Throughput: one item per cycle while the queue is not full; a two-frame queue decouples
// intake from the byte serializer, which drains one 25-beat frame at a time.
// Reset clears averages, offsets and key state and loads register defaults.
module stick_keys_to_sbus_frame
    import sksbus_pkg::*;
#(
    parameter int ADC_BITS  = 10,
    parameter int KEY_COUNT = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [2:0]       operation,
    input  logic [ADC_W-1:0] adc_left_h,
    input  logic [ADC_W-1:0] adc_left_v,
    input  logic [ADC_W-1:0] adc_right_h,
    input  logic [ADC_W-1:0] adc_right_v,
    input  logic [KEY_W-1:0] key_levels,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       frame_byte,
    output logic [4:0]       byte_position,
    output logic             last_byte,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CH_W-1:0]  cfg_wdata
);

    fifo_status_t q_status;
    frame_t       push_frame;
    frame_t       head_frame;
    logic         push;
    logic         pop;

    sksbus_front #(
        .ADC_BITS  (ADC_BITS),
        .KEY_COUNT (KEY_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .adc_left_h  (adc_left_h),
        .adc_left_v  (adc_left_v),
        .adc_right_h (adc_right_h),
        .adc_right_v (adc_right_v),
        .key_levels  (key_levels),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .q_status    (q_status),
        .push        (push),
        .push_frame  (push_frame)
    );

    sksbus_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .head_frame (head_frame),
        .status     (q_status)
    );

    sksbus_ser u_ser (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_frame    (head_frame),
        .q_status      (q_status),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_byte    (frame_byte),
        .byte_position (byte_position),
        .last_byte     (last_byte)
    );

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import sksbus_pkg::*;

    // Operation codes the block must ignore
    localparam logic [2:0] OP_UNDEF_A = 3'd6;
    localparam logic [2:0] OP_UNDEF_B = 3'd7;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam int FRAME_BEATS  = 25;
    localparam int KEYS         = 8;
    localparam int PHASE_ITEMS  = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES  = 30;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [2:0]       op;
        logic [ADC_W-1:0] lh;
        logic [ADC_W-1:0] lv;
        logic [ADC_W-1:0] rh;
        logic [ADC_W-1:0] rv;
        logic [KEY_W-1:0] keys;
    } stick_item_t;

    typedef struct packed {
        logic [7:0] byte_val;
        logic [4:0] pos;
        logic       is_last;
    } frame_beat_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [2:0]       operation;
    logic [ADC_W-1:0] adc_left_h;
    logic [ADC_W-1:0] adc_left_v;
    logic [ADC_W-1:0] adc_right_h;
    logic [ADC_W-1:0] adc_right_v;
    logic [KEY_W-1:0] key_levels;
    logic             out_valid;
    logic             out_ready;
    logic [7:0]       frame_byte;
    logic [4:0]       byte_position;
    logic             last_byte;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [CH_W-1:0]  cfg_wdata;

    // Encoder state mirrored by the testbench
    logic [15:0]     avg_m [STICKS];
    logic [15:0]     cal_m [STICKS];
    logic [15:0]     ofs_m [STICKS];
    logic            held_m [KEYS];
    logic            parity_m [KEYS];
    logic [9:0]      center_m;
    logic [CH_W-1:0] high_m;
    logic [CH_W-1:0] low_m;

    stick_item_t pending_items [$];
    frame_beat_t expected_beats [$];
    stick_item_t offered;
    frame_beat_t got_beat;
    frame_beat_t want_beat;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_reqs;
    int hold_seen;
    int hold_left;
    int error_count;
    int items_taken;
    int beats_checked;
    int queued_items;
    int idle_count;

    stick_keys_to_sbus_frame dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .adc_left_h    (adc_left_h),
        .adc_left_v    (adc_left_v),
        .adc_right_h   (adc_right_h),
        .adc_right_v   (adc_right_v),
        .key_levels    (key_levels),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_byte    (frame_byte),
        .byte_position (byte_position),
        .last_byte     (last_byte),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Advance the mirrored state by one accepted item, queue any frame it emits
    task automatic encode_item(input stick_item_t it);
        logic [ADC_W-1:0]      adc [STICKS];
        logic [CH_W-1:0]       ch [CH_COUNT];
        logic [FRAME_BITS-1:0] packed_ch;
        logic [15:0]           sum;
        logic                  pressed;
        frame_beat_t           beat;
        adc[0] = it.lh;
        adc[1] = it.lv;
        adc[2] = it.rh;
        adc[3] = it.rv;
        case (it.op)
            OP_SAMPLE:
                for (int c = 0; c < STICKS; c++)
                    avg_m[c] = 16'(({1'b0, avg_m[c]} + 17'(adc[c])) >> 1);
            OP_CAL_CLEAR:
                for (int c = 0; c < STICKS; c++)
                    cal_m[c] = '0;
            OP_CAL_SAMPLE:
                for (int c = 0; c < STICKS; c++)
                    cal_m[c] = 16'(({1'b0, cal_m[c]} + 17'(adc[c])) >> 1);
            OP_CAL_FINISH:
                for (int c = 0; c < STICKS; c++)
                    ofs_m[c] = 16'(center_m) - cal_m[c];
            OP_KEY_SCAN:
                for (int k = 1; k < KEYS; k++)
                begin
                    pressed = !it.keys[k];
                    if (pressed && !held_m[k])
                    begin
                        parity_m[k] = !parity_m[k];
                        held_m[k] = 1'b1;
                    end
                    else if (!pressed && held_m[k])
                        held_m[k] = 1'b0;
                end
            OP_EMIT:
            begin
                for (int c = 0; c < STICKS; c++)
                begin
                    sum = avg_m[c] + ofs_m[c];
                    avg_m[c] = {sum[14:0], 1'b0};
                    ch[c] = avg_m[c][CH_W-1:0];
                end
                // Preset while key 1 is held, then key 2 override
                if (held_m[1])
                begin
                    ch[0] = high_m;
                    ch[1] = high_m;
                    ch[2] = low_m;
                    ch[3] = high_m;
                end
                if (held_m[2])
                begin
                    ch[0] = low_m;
                    ch[1] = high_m;
                end
                for (int c = STICKS; c < CH_COUNT; c++)
                    ch[c] = CH_FULL;
                for (int k = 3; k < KEYS; k++)
                    ch[k + 3] = parity_m[k] ? low_m : high_m;
                for (int c = 0; c < CH_COUNT; c++)
                    packed_ch[c*CH_W +: CH_W] = ch[c];
                for (int b = 0; b < FRAME_BEATS; b++)
                begin
                    if (b == 0)
                        beat.byte_val = HEADER_BYTE;
                    else if (b <= DATA_BYTES)
                        beat.byte_val = packed_ch[(b-1)*8 +: 8];
                    else
                        beat.byte_val = 8'h00;
                    beat.pos = 5'(b);
                    beat.is_last = (5'(b) == LAST_POS);
                    expected_beats.push_back(beat);
                end
            end
            default: ;
        endcase
    endtask

    // Driver: offer queued items, hold each until accepted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                encode_item(offered);
                items_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered = pending_items.pop_front();
                    in_valid    <= 1'b1;
                    operation   <= offered.op;
                    adc_left_h  <= offered.lh;
                    adc_left_v  <= offered.lv;
                    adc_right_h <= offered.rh;
                    adc_right_v <= offered.rv;
                    key_levels  <= offered.keys;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each frame beat, drive output backpressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got_beat = '{frame_byte, byte_position, last_byte};
                beats_checked++;
                if (expected_beats.size() == 0)
                    flag_error($sformatf("beat with no frame pending: byte %02h pos %0d last %0b",
                                         got_beat.byte_val, got_beat.pos, got_beat.is_last));
                else
                begin
                    want_beat = expected_beats.pop_front();
                    if (got_beat !== want_beat)
                        flag_error($sformatf(
                            "beat mismatch: expected byte %02h pos %0d last %0b, got %02h %0d %0b",
                            want_beat.byte_val, want_beat.pos, want_beat.is_last,
                            got_beat.byte_val, got_beat.pos, got_beat.is_last));
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= STALL_LIMIT)
        begin
            $display("[%0t] ERROR: no beat accepted for %0d cycles", $realtime, STALL_LIMIT);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic push_item(input logic [2:0] op, input logic [ADC_W-1:0] lh,
                             input logic [ADC_W-1:0] lv, input logic [ADC_W-1:0] rh,
                             input logic [ADC_W-1:0] rv, input logic [KEY_W-1:0] keys);
        stick_item_t it;
        it = '{op, lh, lv, rh, rv, keys};
        pending_items.push_back(it);
        if (op != OP_UNDEF_A && op != OP_UNDEF_B)
            queued_items++;
    endtask

    function automatic logic [ADC_W-1:0] rand_adc();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return ADC_W'($urandom);
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] rand_keys();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            default: return KEY_W'($urandom);
        endcase
    endfunction

    task automatic push_rand(input logic [2:0] op);
        push_item(op, rand_adc(), rand_adc(), rand_adc(), rand_adc(), rand_keys());
    endtask

    // Queue one short sequence of the kind the encoder sees in use
    task automatic push_burst();
        int n;
        n = $urandom_range(1, 3);
        case ($urandom_range(9))
            0, 1, 2, 3, 4:
            begin
                repeat (n) push_rand(OP_SAMPLE);
                push_rand(OP_EMIT);
            end
            5:
            begin
                push_rand(OP_CAL_CLEAR);
                repeat (n) push_rand(OP_CAL_SAMPLE);
                push_rand(OP_CAL_FINISH);
                push_rand(OP_SAMPLE);
                push_rand(OP_EMIT);
            end
            6, 7:
            begin
                repeat (n) push_rand(OP_KEY_SCAN);
                push_rand(OP_EMIT);
            end
            8:
                push_rand($urandom_range(1) ? OP_UNDEF_A : OP_UNDEF_B);
            default:
                push_rand(3'($urandom));
        endcase
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CH_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_CENTER: center_m = val[9:0];
            REG_HIGH:   high_m = val;
            REG_LOW:    low_m = val;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold the sender until every expected beat has arrived
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_beats.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        queued_items = 0;
        while (queued_items < PHASE_ITEMS)
            push_burst();
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = '0;
        adc_left_h = '0;
        adc_left_v = '0;
        adc_right_h = '0;
        adc_right_v = '0;
        key_levels = '1;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_reqs = 0;
        hold_seen = 0;
        hold_left = 0;
        error_count = 0;
        items_taken = 0;
        beats_checked = 0;
        queued_items = 0;
        idle_count = 0;
        center_m = CENTER_RST;
        high_m = HIGH_RST;
        low_m = LOW_RST;
        for (int c = 0; c < STICKS; c++)
        begin
            avg_m[c] = '0;
            cal_m[c] = '0;
            ofs_m[c] = '0;
        end
        for (int k = 0; k < KEYS; k++)
        begin
            held_m[k] = 1'b0;
            parity_m[k] = 1'b0;
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset frame, full-scale sticks, negative offsets, key cases
        push_item(OP_EMIT, '0, '0, '0, '0, '1);
        push_item(OP_SAMPLE, '1, '1, '1, '1, '1);
        push_item(OP_SAMPLE, '1, '0, '1, '0, '1);
        push_item(OP_EMIT, '0, '0, '0, '0, '1);
        push_item(OP_CAL_CLEAR, '1, '1, '1, '1, '0);
        push_item(OP_CAL_SAMPLE, '1, '1, '1, '1, '1);
        push_item(OP_CAL_SAMPLE, '1, '1, '1, '1, '1);
        push_item(OP_CAL_FINISH, '0, '0, '0, '0, '1);
        push_item(OP_EMIT, '0, '0, '0, '0, '1);
        // all keys pressed at once: preset and key 2 override together
        push_item(OP_KEY_SCAN, '1, '1, '1, '1, 8'h00);
        push_item(OP_EMIT, '0, '0, '0, '0, '1);
        // release all but key 2
        push_item(OP_KEY_SCAN, '0, '0, '0, '0, 8'hFB);
        push_item(OP_EMIT, '0, '0, '0, '0, '1);
        // key 1 alone, key 2 released
        push_item(OP_KEY_SCAN, '0, '0, '0, '0, 8'hFD);
        push_item(OP_EMIT, '0, '0, '0, '0, '1);
        // key 0 low only: it is never scanned
        push_item(OP_KEY_SCAN, '0, '0, '0, '0, 8'hFE);
        push_item(OP_EMIT, '0, '0, '0, '0, '1);
        // undefined operations change nothing
        push_item(OP_UNDEF_A, '1, '1, '1, '1, '0);
        push_item(OP_UNDEF_B, '1, '1, '1, '1, '0);
        push_item(OP_EMIT, '1, '1, '1, '1, '0);
        push_item(OP_SAMPLE, '0, '0, '0, '0, '0);
        push_item(OP_CAL_CLEAR, '0, '0, '0, '0, '0);
        push_item(OP_CAL_FINISH, '0, '0, '0, '0, '0);
        push_item(OP_EMIT, '0, '0, '0, '0, '0);
        wait_drained();

        run_phase(0, 0);

        // Low extremes; center write with bit 10 set must drop it
        write_reg(REG_CENTER, 11'h400);
        write_reg(REG_HIGH, 11'h7FF);
        write_reg(REG_LOW, 11'h000);
        end_writes();
        run_phase(54, 0);

        write_reg(REG_CENTER, 11'h7FF);
        write_reg(REG_HIGH, 11'h000);
        write_reg(REG_LOW, 11'h7FF);
        write_reg(REG_UNUSED, 11'h2AA);
        end_writes();
        run_phase(0, 54);

        write_reg(REG_CENTER, CH_W'($urandom));
        write_reg(REG_HIGH, CH_W'($urandom));
        write_reg(REG_LOW, CH_W'($urandom));
        write_reg(REG_UNUSED, CH_W'($urandom));
        end_writes();
        run_phase(35, 35);

        // Long output hold-off while emits keep coming: input must back up
        write_reg(REG_CENTER, {1'b0, CENTER_RST});
        write_reg(REG_HIGH, HIGH_RST);
        write_reg(REG_LOW, LOW_RST);
        end_writes();
        @(negedge clk);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_reqs++;
        for (int i = 0; i < 16; i++)
            push_rand((i % 4 == 3) ? OP_SAMPLE : OP_EMIT);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_beats.size() != 0)
            flag_error($sformatf("%0d frame beats never arrived", expected_beats.size()));
        $display("Sent %0d items, checked %0d frame beats (%0d frames) over five idle/stall",
                 items_taken, beats_checked, beats_checked / FRAME_BEATS);
        $display("phases with register extremes and an output hold-off; %0d errors",
                 error_count);
        if (error_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

### stick_keys_to_sbus_frame.f
design/sksbus_pkg.sv
design/sksbus_front.sv
design/sksbus_fifo.sv
design/sksbus_ser.sv
design/stick_keys_to_sbus_frame.sv
test/tb_top.sv
